// File: rtl/core/fixed_slot_pool_allocator_top_defines.svh
// Assertion macros for the fixed slot pool allocator.
// Used by the port checker; needs nothing else.
`ifndef FIXED_SLOT_POOL_ALLOCATOR_TOP_DEFINES_SVH
`define FIXED_SLOT_POOL_ALLOCATOR_TOP_DEFINES_SVH

// Check cons in the same cycle as ante.
`define FSPA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fspa port check failed");

// Check cons in the cycle after ante.
`define FSPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fspa port check failed");

`endif

// File: rtl/core/fspa_pkg.sv
// Shared constants, codes and control types of the fixed slot pool allocator.
// Depends on nothing.
package fspa_pkg;

	localparam int MAX_SLOTS  = 1024;
	localparam int INDEX_BITS = 16;
	localparam int HANDLE_W   = 64;
	localparam int OFF_W      = HANDLE_W - INDEX_BITS;
	localparam int SLOT_W     = $clog2(MAX_SLOTS);
	localparam int CNT_W      = SLOT_W + 1;

	localparam int OP_W       = 2;
	localparam int CPU_W      = 12;
	localparam int STATUS_W   = 2;
	localparam int ROFF_W     = 42;
	localparam int ORDER_W    = 5;
	localparam int REGION_W   = 11;
	localparam int POOL_W     = 16;
	localparam int PROD_W     = CPU_W + REGION_W;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [OP_W-1:0] OP_ALLOC     = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE      = 2'd1;
	localparam logic [OP_W-1:0] OP_TRANSLATE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_MEM     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_FREE   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_WRONG_POOL = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_ORDER   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_SLOTS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_NUMBER  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROBUST       = 2'd3;

	localparam logic [ORDER_W-1:0]  SLOT_ORDER_RST   = 5'd3;
	localparam logic [REGION_W-1:0] REGION_SLOTS_RST = 11'd1024;
	localparam logic [POOL_W-1:0]   POOL_NUMBER_RST  = 16'd1;

	typedef struct packed {
		logic capture;
		logic finish;
		logic clear_step;
	} fspa_cmd_t;

	typedef struct packed {
		logic clear_last;
	} fspa_stat_t;

endpackage

// File: rtl/core/fspa_req_if.sv
// Request channel of the fixed slot pool allocator: opcode, handle, cpu.
// Depends on fspa_pkg.
interface fspa_req_if import fspa_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     opcode;
	logic [HANDLE_W-1:0] handle_in;
	logic [CPU_W-1:0]    cpu_number;

	modport source (output valid, opcode, handle_in, cpu_number, input ready);
	modport sink (input valid, opcode, handle_in, cpu_number, output ready);
endinterface

// File: rtl/core/fspa_rsp_if.sv
// Result channel of the fixed slot pool allocator: status, handle, offset.
// Depends on fspa_pkg.
interface fspa_rsp_if import fspa_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [HANDLE_W-1:0] handle_out;
	logic [ROFF_W-1:0]   region_offset;

	modport source (output valid, status, handle_out, region_offset, input ready);
	modport sink (input valid, status, handle_out, region_offset, output ready);
endinterface

// File: rtl/core/fspa_cfg_if.sv
// Configuration write channel of the fixed slot pool allocator.
// Depends on fspa_pkg.
interface fspa_cfg_if import fspa_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/fixed_slot_pool_allocator_top.sv
// Fixed slot pool allocator: alloc, free and translate over one pool of equal slots.
// The result is registered, and req.ready stays low until it is, since each item
// takes the registered read of the free stack and in-use bitmap, then the write-back.
// A stalled result holds the next item in the execute state until the result is taken.
// Reset: control registers reset, then a clear pass zeroes the in-use bitmap,
// with req.ready low. Depends on fspa_pkg, the channel interfaces, fspa_ctrl, fspa_dp.
module fixed_slot_pool_allocator_top import fspa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	fspa_req_if.sink    req,
	fspa_rsp_if.source  rsp,
	fspa_cfg_if.sink    cfg
);

	fspa_cmd_t  cmd;
	fspa_stat_t stat;

	assign cfg.ready = 1'b1;

	fspa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	fspa_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.opcode        (req.opcode),
		.handle_in     (req.handle_in),
		.cpu_number    (req.cpu_number),
		.cfg_we        (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.status        (rsp.status),
		.handle_out    (rsp.handle_out),
		.region_offset (rsp.region_offset)
	);

endmodule

// File: rtl/core/fspa_ctrl.sv
// Controller of the fixed slot pool allocator: clear pass, accept, finish, result valid.
// Depends on fspa_pkg.
module fspa_ctrl import fspa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	input  fspa_stat_t stat,
	output fspa_cmd_t  cmd
);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_EXEC  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd.capture    = (state_q == S_IDLE) && req_valid;
		cmd.finish     = (state_q == S_EXEC) && (!out_valid_q || rsp_ready);
		cmd.clear_step = (state_q == S_CLEAR);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (stat.clear_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (cmd.finish) state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// File: rtl/core/fspa_dp.sv
// Datapath of the fixed slot pool allocator: registers, free stack, in-use bitmap,
// translate product and result register. Depends on fspa_pkg.
module fspa_dp import fspa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fspa_cmd_t             cmd,
	output fspa_stat_t            stat,
	input  logic [OP_W-1:0]       opcode,
	input  logic [HANDLE_W-1:0]   handle_in,
	input  logic [CPU_W-1:0]      cpu_number,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic [STATUS_W-1:0]   status,
	output logic [HANDLE_W-1:0]   handle_out,
	output logic [ROFF_W-1:0]     region_offset
);

	logic [ORDER_W-1:0]  slot_order_q;
	logic [REGION_W-1:0] region_slots_q;
	logic [POOL_W-1:0]   pool_number_q;
	logic                robust_q;

	logic [CNT_W-1:0]    free_count_q;
	logic [CNT_W-1:0]    next_fresh_q;
	logic [SLOT_W-1:0]   clear_cnt_q;

	logic [SLOT_W-1:0]   stack_mem [MAX_SLOTS];
	logic                used_mem  [MAX_SLOTS];

	logic [OP_W-1:0]     op_s1;
	logic                pool_ok_s1;
	logic                range_ok_s1;
	logic [SLOT_W-1:0]   slot_s1;
	logic [ROFF_W-1:0]   offset_s1;
	logic [PROD_W-1:0]   prod_s1;
	logic [SLOT_W-1:0]   stack_rd_s1;
	logic                used_rd_s1;

	logic [STATUS_W-1:0] status_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [ROFF_W-1:0]   roff_q;

	logic [CNT_W-1:0]    limit;
	logic [OFF_W-1:0]    slot_full;
	logic                range_ok;
	logic [CNT_W-1:0]    fc_dec;

	logic                pop;
	logic                bump;
	logic [SLOT_W-1:0]   alloc_slot;
	logic                push;

	logic                used_we;
	logic [SLOT_W-1:0]   used_waddr;
	logic                used_wdata;

	logic [STATUS_W-1:0] status_d;
	logic [HANDLE_W-1:0] handle_d;
	logic [ROFF_W-1:0]   roff_d;

	assign limit = (region_slots_q > REGION_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
		: CNT_W'(region_slots_q);
	assign slot_full = handle_in[OFF_W-1:0] >> slot_order_q;
	assign range_ok  = (slot_full[OFF_W-1:CNT_W] == '0) && (slot_full[CNT_W-1:0] < limit);
	assign fc_dec    = free_count_q - CNT_W'(1);

	assign pop        = (free_count_q != '0);
	assign bump       = !pop && (next_fresh_q < limit);
	assign alloc_slot = pop ? stack_rd_s1 : next_fresh_q[SLOT_W-1:0];
	assign push       = (op_s1 == OP_FREE) && pool_ok_s1 && range_ok_s1
		&& !(robust_q && !used_rd_s1) && (free_count_q < CNT_W'(MAX_SLOTS));

	assign stat.clear_last = (clear_cnt_q == '1);

	always_comb begin
		used_we    = 1'b0;
		used_waddr = clear_cnt_q;
		used_wdata = 1'b0;
		if (cmd.clear_step) begin
			used_we = 1'b1;
		end else if (cmd.finish && (op_s1 == OP_ALLOC) && (pop || bump)) begin
			used_we    = 1'b1;
			used_waddr = alloc_slot;
			used_wdata = 1'b1;
		end else if (cmd.finish && push) begin
			used_we    = 1'b1;
			used_waddr = slot_s1;
		end
	end

	always_comb begin
		status_d = ST_OK;
		handle_d = '0;
		roff_d   = '0;
		case (op_s1)
			OP_ALLOC: begin
				if (pop || bump) begin
					handle_d = {pool_number_q, OFF_W'(alloc_slot) << slot_order_q};
				end else begin
					status_d = ST_NO_MEM;
				end
			end
			OP_FREE: begin
				if (!pool_ok_s1) status_d = ST_WRONG_POOL;
				else if (!push) status_d = ST_BAD_FREE;
			end
			OP_TRANSLATE: begin
				if (!pool_ok_s1) status_d = ST_WRONG_POOL;
				else roff_d = (ROFF_W'(prod_s1) << slot_order_q) + offset_s1;
			end
			default: status_d = ST_OK;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_s1       <= opcode;
			pool_ok_s1  <= (handle_in[HANDLE_W-1:OFF_W] == pool_number_q);
			range_ok_s1 <= range_ok;
			slot_s1     <= slot_full[SLOT_W-1:0];
			offset_s1   <= handle_in[ROFF_W-1:0];
			prod_s1     <= PROD_W'(cpu_number) * PROD_W'(region_slots_q);
			stack_rd_s1 <= stack_mem[fc_dec[SLOT_W-1:0]];
			used_rd_s1  <= used_mem[slot_full[SLOT_W-1:0]];
		end
		if (cmd.finish && push) stack_mem[free_count_q[SLOT_W-1:0]] <= slot_s1;
		if (used_we) used_mem[used_waddr] <= used_wdata;
		if (cmd.finish) begin
			status_q <= status_d;
			handle_q <= handle_d;
			roff_q   <= roff_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_order_q   <= SLOT_ORDER_RST;
			region_slots_q <= REGION_SLOTS_RST;
			pool_number_q  <= POOL_NUMBER_RST;
			robust_q       <= 1'b0;
			free_count_q   <= '0;
			next_fresh_q   <= '0;
			clear_cnt_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_SLOT_ORDER:   slot_order_q   <= cfg_data[ORDER_W-1:0];
					CFG_REGION_SLOTS: region_slots_q <= cfg_data[REGION_W-1:0];
					CFG_POOL_NUMBER:  pool_number_q  <= cfg_data[POOL_W-1:0];
					CFG_ROBUST:       robust_q       <= cfg_data[0];
					default:          robust_q       <= robust_q;
				endcase
			end
			if (cmd.clear_step) clear_cnt_q <= clear_cnt_q + SLOT_W'(1);
			if (cmd.finish && (op_s1 == OP_ALLOC)) begin
				if (pop) free_count_q <= fc_dec;
				else if (bump) next_fresh_q <= next_fresh_q + CNT_W'(1);
			end
			if (cmd.finish && push) free_count_q <= free_count_q + CNT_W'(1);
		end
	end

	assign status        = status_q;
	assign handle_out    = handle_q;
	assign region_offset = roff_q;

endmodule

// File: rtl/core/fspa_checker.sv
// Port checker for the fixed slot pool allocator, bound to the top level.
// Depends on fspa_pkg and fixed_slot_pool_allocator_top_defines.svh.
`include "fixed_slot_pool_allocator_top_defines.svh"

module fspa_checker import fspa_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [STATUS_W-1:0] status,
	input logic [HANDLE_W-1:0] handle_out,
	input logic [ROFF_W-1:0]   region_offset
);

	`FSPA_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	`FSPA_ASSERT_NEXT(a_rsp_stable, clk, arst_n, rsp_valid && !rsp_ready, $stable(status) && $stable(handle_out) && $stable(region_offset))
	`FSPA_ASSERT_NEXT(a_req_spacing, clk, arst_n, req_valid && req_ready, !req_ready)
	`FSPA_ASSERT_SAME(a_fail_zero, clk, arst_n, rsp_valid && (status != ST_OK), (handle_out == '0) && (region_offset == '0))

endmodule

bind fixed_slot_pool_allocator_top fspa_checker u_fspa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.status        (rsp.status),
	.handle_out    (rsp.handle_out),
	.region_offset (rsp.region_offset)
);
